@@ hw/rtl/qpht_pkg.sv @@
// shared types and constants for the quadratic probe hash table
`default_nettype none

package qpht_pkg;

  localparam int TABLE_SIZE = 1024;
  localparam int SLOT_W     = $clog2(TABLE_SIZE);
  localparam int KEY_W      = 31;
  localparam int MOD_W      = 11;
  localparam int LIMIT_W    = 10;
  localparam int CNT_W      = 10;
  localparam int STATUS_W   = 2;
  localparam int ROW_W      = KEY_W + 1;
  localparam int DIV_CNT_W  = $clog2(KEY_W);
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = MOD_W;

  localparam logic [MOD_W-1:0]   HASH_MOD_RST    = MOD_W'(1021);
  localparam logic [LIMIT_W-1:0] PROBE_LIMIT_RST = LIMIT_W'(1023);

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_HASH_MOD    = cfg_idx_t'(0);
  localparam cfg_idx_t CFG_PROBE_LIMIT = cfg_idx_t'(1);

  typedef enum logic [STATUS_W-1:0] {
    RES_FOUND = 2'd0,
    RES_EMPTY = 2'd1,
    RES_LIMIT = 2'd2
  } res_status_t;

  typedef enum logic [2:0] {
    CS_CLEAR,
    CS_IDLE,
    CS_DIV,
    CS_READ,
    CS_CHECK,
    CS_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic load;
    logic div_step;
    logic clr_step;
    logic mem_rd;
    logic probe_next;
    logic fin;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic div_last;
    logic done;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

@@ hw/rtl/qpht_if.sv @@
// item channel interfaces for requests and results
`default_nettype none

interface qpht_in_if;
  logic                       valid;
  logic                       ready;
  logic                       req_type;
  logic [qpht_pkg::KEY_W-1:0] key;

  modport source (output valid, output req_type, output key, input ready);
  modport sink (input valid, input req_type, input key, output ready);
endinterface

interface qpht_out_if;
  logic                          valid;
  logic                          ready;
  logic [qpht_pkg::SLOT_W-1:0]   slot;
  logic [qpht_pkg::STATUS_W-1:0] status;
  logic [qpht_pkg::CNT_W-1:0]    probe_count;

  modport source (output valid, output slot, output status, output probe_count, input ready);
  modport sink (input valid, input slot, input status, input probe_count, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/quadratic_probe_hash_table_unit.sv @@
// an item passes the serial modulo of its key, then a read and a check for each slot probed, then the result register
// the next item can be accepted in the cycle after the result is loaded, even if it is not yet taken
// throughput is set by the bit-serial modulo and the probe reads of the slot memory
// after reset a clearing pass over all 1024 slots empties the table; no item is accepted meanwhile
// reset sets hash_modulus to 1021 and probe_limit to 1023
`default_nettype none

module quadratic_probe_hash_table_unit (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  qpht_in_if.sink                                  in_chan,
  qpht_out_if.source                               out_chan,
  input  wire logic                                cfg_we,
  input  wire qpht_pkg::cfg_idx_t                  cfg_idx,
  input  wire logic [qpht_pkg::CFG_DATA_W-1:0]     cfg_data
);

  logic [qpht_pkg::MOD_W-1:0]   hash_mod_r;
  logic [qpht_pkg::LIMIT_W-1:0] probe_limit_r;
  qpht_pkg::dp_cmd_t            cmd;
  qpht_pkg::dp_sts_t            sts;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_mod_r    <= qpht_pkg::HASH_MOD_RST;
      probe_limit_r <= qpht_pkg::PROBE_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        qpht_pkg::CFG_HASH_MOD:    hash_mod_r    <= cfg_data[qpht_pkg::MOD_W-1:0];
        qpht_pkg::CFG_PROBE_LIMIT: probe_limit_r <= cfg_data[qpht_pkg::LIMIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  qpht_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  qpht_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_req_type     (in_chan.req_type),
    .in_key          (in_chan.key),
    .hash_mod        (hash_mod_r),
    .probe_limit     (probe_limit_r),
    .out_valid       (out_chan.valid),
    .out_ready       (out_chan.ready),
    .out_slot        (out_chan.slot),
    .out_status      (out_chan.status),
    .out_probe_count (out_chan.probe_count)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> !in_chan.ready)
    else $error("input ready while an item is in work");

  a_limit_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.status == qpht_pkg::RES_LIMIT)
      |-> (out_chan.probe_count == probe_limit_r))
    else $error("probe limit result with wrong probe count");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> (out_chan.probe_count <= probe_limit_r))
    else $error("probe count beyond probe limit");

  a_no_result_on_fin: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fin |=> !$rose(out_chan.valid))
    else $error("result valid in the cycle after probing stopped");

endmodule

`default_nettype wire

@@ hw/rtl/qpht_ctrl.sv @@
// sequencing state machine for table clear, hashing and probing
`default_nettype none

module qpht_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire qpht_pkg::dp_sts_t sts,
  output qpht_pkg::dp_cmd_t      cmd
);

  qpht_pkg::ctrl_state_t state_r;
  qpht_pkg::ctrl_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= qpht_pkg::CS_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      qpht_pkg::CS_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          state_nxt = qpht_pkg::CS_IDLE;
        end
      end
      qpht_pkg::CS_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = qpht_pkg::CS_DIV;
        end
      end
      qpht_pkg::CS_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = qpht_pkg::CS_READ;
        end
      end
      qpht_pkg::CS_READ: begin
        cmd.mem_rd = 1'b1;
        state_nxt  = qpht_pkg::CS_CHECK;
      end
      qpht_pkg::CS_CHECK: begin
        if (sts.done) begin
          cmd.fin   = 1'b1;
          state_nxt = qpht_pkg::CS_DONE;
        end else begin
          cmd.probe_next = 1'b1;
          state_nxt      = qpht_pkg::CS_READ;
        end
      end
      qpht_pkg::CS_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = qpht_pkg::CS_IDLE;
        end
      end
      default: begin
        state_nxt = qpht_pkg::CS_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ hw/rtl/qpht_dp.sv @@
// datapath: serial modulo, probe sequence, slot memory and result register
`default_nettype none

module qpht_dp (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire qpht_pkg::dp_cmd_t               cmd,
  output qpht_pkg::dp_sts_t                    sts,
  input  wire logic                            in_req_type,
  input  wire logic [qpht_pkg::KEY_W-1:0]      in_key,
  input  wire logic [qpht_pkg::MOD_W-1:0]      hash_mod,
  input  wire logic [qpht_pkg::LIMIT_W-1:0]    probe_limit,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [qpht_pkg::SLOT_W-1:0]          out_slot,
  output logic [qpht_pkg::STATUS_W-1:0]        out_status,
  output logic [qpht_pkg::CNT_W-1:0]           out_probe_count
);

  logic [qpht_pkg::ROW_W-1:0]     mem [qpht_pkg::TABLE_SIZE];
  logic [qpht_pkg::ROW_W-1:0]     rd_row_r;

  logic                           req_r;
  logic [qpht_pkg::KEY_W-1:0]     key_r;
  logic [qpht_pkg::KEY_W-1:0]     key_sh_r;
  logic [qpht_pkg::MOD_W-1:0]     rem_r;
  logic [qpht_pkg::MOD_W-1:0]     rem_nxt;
  logic [qpht_pkg::DIV_CNT_W-1:0] div_cnt_r;
  logic [qpht_pkg::SLOT_W-1:0]    pos_r;
  logic [qpht_pkg::CNT_W-1:0]     steps_r;
  logic [qpht_pkg::CNT_W-1:0]     steps_nxt;
  logic [qpht_pkg::SLOT_W-1:0]    sq_r;
  logic [qpht_pkg::SLOT_W-1:0]    sq_nxt;
  logic [qpht_pkg::SLOT_W-1:0]    odd_r;
  logic [qpht_pkg::SLOT_W-1:0]    home;
  logic [qpht_pkg::SLOT_W-1:0]    clr_cnt_r;
  qpht_pkg::res_status_t          res_status_r;
  qpht_pkg::res_status_t          status_c;

  logic [qpht_pkg::MOD_W-1:0]     m_eff;
  logic [qpht_pkg::MOD_W:0]       m_ext;
  logic [qpht_pkg::MOD_W:0]       div_t;

  logic                           occ;
  logic                           match;
  logic                           empty;
  logic                           limit;

  logic                           mem_we;
  logic [qpht_pkg::SLOT_W-1:0]    mem_waddr;
  logic [qpht_pkg::ROW_W-1:0]     mem_wdata;

  logic                           out_valid_r;
  logic [qpht_pkg::SLOT_W-1:0]    out_slot_r;
  qpht_pkg::res_status_t          out_status_r;
  logic [qpht_pkg::CNT_W-1:0]     out_cnt_r;

  // restoring remainder, one key bit per cycle
  assign m_eff   = (hash_mod == '0) ? qpht_pkg::MOD_W'(1) : hash_mod;
  assign m_ext   = {1'b0, m_eff};
  assign div_t   = {rem_r, key_sh_r[qpht_pkg::KEY_W-1]};
  assign rem_nxt = (div_t >= m_ext) ? qpht_pkg::MOD_W'(div_t - m_ext)
                                    : div_t[qpht_pkg::MOD_W-1:0];

  assign home      = rem_r[qpht_pkg::SLOT_W-1:0];
  assign steps_nxt = steps_r + qpht_pkg::CNT_W'(1);
  assign sq_nxt    = sq_r + odd_r;

  assign occ   = rd_row_r[qpht_pkg::KEY_W];
  assign match = occ && (rd_row_r[qpht_pkg::KEY_W-1:0] == key_r);
  assign empty = !occ;
  assign limit = steps_r >= qpht_pkg::CNT_W'(probe_limit);

  always_comb begin
    if (empty) begin
      status_c = qpht_pkg::RES_EMPTY;
    end else if (match) begin
      status_c = qpht_pkg::RES_FOUND;
    end else begin
      status_c = qpht_pkg::RES_LIMIT;
    end
  end

  assign sts.clr_last = &clr_cnt_r;
  assign sts.div_last = div_cnt_r == qpht_pkg::DIV_CNT_W'(qpht_pkg::KEY_W - 1);
  assign sts.done     = empty || match || limit;
  assign sts.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_step) begin
      clr_cnt_r <= clr_cnt_r + qpht_pkg::SLOT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r     <= in_req_type;
      key_r     <= in_key;
      key_sh_r  <= in_key;
      rem_r     <= '0;
      div_cnt_r <= '0;
    end
    if (cmd.div_step) begin
      rem_r     <= rem_nxt;
      key_sh_r  <= key_sh_r << 1;
      div_cnt_r <= div_cnt_r + qpht_pkg::DIV_CNT_W'(1);
      if (sts.div_last) begin
        pos_r   <= rem_nxt[qpht_pkg::SLOT_W-1:0];
        steps_r <= '0;
        sq_r    <= '0;
        odd_r   <= qpht_pkg::SLOT_W'(1);
      end
    end
    if (cmd.probe_next) begin
      steps_r <= steps_nxt;
      if (steps_nxt[0]) begin
        sq_r  <= sq_nxt;
        odd_r <= odd_r + qpht_pkg::SLOT_W'(2);
        pos_r <= home + sq_nxt;
      end else begin
        pos_r <= home - sq_r;
      end
    end
    if (cmd.fin) begin
      res_status_r <= status_c;
    end
  end

  assign mem_we    = cmd.clr_step || (cmd.fin && empty && req_r);
  assign mem_waddr = cmd.clr_step ? clr_cnt_r : pos_r;
  assign mem_wdata = cmd.clr_step ? '0 : {1'b1, key_r};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.mem_rd) begin
      rd_row_r <= mem[pos_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_slot_r   <= pos_r;
      out_status_r <= res_status_r;
      out_cnt_r    <= steps_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_slot        = out_slot_r;
  assign out_status      = out_status_r;
  assign out_probe_count = out_cnt_r;

endmodule

`default_nettype wire

@@ sim/quadratic_probe_hash_table_unit_tb.sv @@
// testbench for quadratic_probe_hash_table_unit: directed table and random items, checked by a slot-table predictor
`timescale 1ns / 1ps

module quadratic_probe_hash_table_unit_tb;

  localparam int unsigned LIMIT_CYCLES = 16_000_000;
  localparam int unsigned NUM_PHASES   = 7;

  typedef struct packed {
    logic [qpht_pkg::SLOT_W-1:0] slot;
    qpht_pkg::res_status_t       status;
    logic [qpht_pkg::CNT_W-1:0]  probe_count;
  } table_result_t;

  typedef struct {
    logic                            is_cfg;
    qpht_pkg::cfg_idx_t              idx;
    logic [qpht_pkg::CFG_DATA_W-1:0] data;
    logic                            rt;
    logic [qpht_pkg::KEY_W-1:0]      key;
    logic                            typed;
    table_result_t                   want;
  } dir_row_t;

  logic                            clk;
  logic                            rst_n;
  logic                            cfg_we;
  qpht_pkg::cfg_idx_t              cfg_idx;
  logic [qpht_pkg::CFG_DATA_W-1:0] cfg_data;

  qpht_in_if  req_bus ();
  qpht_out_if res_bus ();

  quadratic_probe_hash_table_unit DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (req_bus),
    .out_chan (res_bus),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  // predictor state
  logic [qpht_pkg::KEY_W-1:0]   slot_key [qpht_pkg::TABLE_SIZE];
  logic                         slot_used [qpht_pkg::TABLE_SIZE];
  logic [qpht_pkg::MOD_W-1:0]   cur_mod;
  logic [qpht_pkg::LIMIT_W-1:0] cur_limit;
  logic [qpht_pkg::KEY_W-1:0]   stored_keys [$];
  table_result_t                awaited_results [$];
  dir_row_t                     dir_rows [$];

  int unsigned errors;
  int unsigned results_seen;
  int unsigned finds_sent;
  int unsigned inserts_sent;
  int unsigned settings_used;
  int unsigned status_seen [3];

  int unsigned phase_mod [NUM_PHASES]   = '{1021, 509, 2, 1024, 0, 2047, 1021};
  int unsigned phase_limit [NUM_PHASES] = '{1023, 40, 8, 1, 5, 300, 1023};
  int unsigned phase_items [NUM_PHASES] = '{400, 300, 200, 200, 100, 200, 200};

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic table_result_t probe_table(input logic ins,
                                                input logic [qpht_pkg::KEY_W-1:0] k);
    int unsigned   m;
    int unsigned   home;
    int unsigned   pos;
    int unsigned   steps;
    int unsigned   i;
    int unsigned   sq;
    int unsigned   tsize;
    logic          done;
    table_result_t r;
    tsize = qpht_pkg::TABLE_SIZE;
    m = (cur_mod == '0) ? 32'd1 : 32'(cur_mod);
    home = (32'(k) % m) % tsize;
    pos = home;
    steps = 0;
    done = 1'b0;
    r = '0;
    while (!done) begin
      if (!slot_used[pos]) begin
        r.status = qpht_pkg::RES_EMPTY;
        if (ins) begin
          slot_key[pos] = k;
          slot_used[pos] = 1'b1;
          stored_keys.push_back(k);
        end
        done = 1'b1;
      end else if (slot_key[pos] == k) begin
        r.status = qpht_pkg::RES_FOUND;
        done = 1'b1;
      end else if (steps >= cur_limit) begin
        r.status = qpht_pkg::RES_LIMIT;
        done = 1'b1;
      end else begin
        steps++;
        i = (steps + 1) / 2;
        sq = (i * i) % tsize;
        if (steps % 2 == 1) begin
          pos = (home + sq) % tsize;
        end else begin
          pos = (home + tsize - sq) % tsize;
        end
      end
    end
    r.slot = qpht_pkg::SLOT_W'(pos);
    r.probe_count = qpht_pkg::CNT_W'(steps);
    return r;
  endfunction

  function automatic logic [qpht_pkg::KEY_W-1:0] rand_key();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 5) begin
      return qpht_pkg::KEY_W'($urandom_range(0, 4095));
    end else if (sel < 8) begin
      return qpht_pkg::KEY_W'($urandom_range(0, 1 << 20));
    end else begin
      return qpht_pkg::KEY_W'($urandom() >> 1);
    end
  endfunction

  function automatic void add_reg(input qpht_pkg::cfg_idx_t idx, input int unsigned val);
    dir_row_t row;
    row = '{default: '0};
    row.is_cfg = 1'b1;
    row.idx = idx;
    row.data = qpht_pkg::CFG_DATA_W'(val);
    dir_rows.push_back(row);
  endfunction

  function automatic void add_item(input logic rt, input int unsigned k);
    dir_row_t row;
    row = '{default: '0};
    row.rt = rt;
    row.key = qpht_pkg::KEY_W'(k);
    dir_rows.push_back(row);
  endfunction

  function automatic void add_known(input logic rt, input int unsigned k,
                                    input int unsigned slot, input qpht_pkg::res_status_t st,
                                    input int unsigned pc);
    dir_row_t row;
    row = '{default: '0};
    row.rt = rt;
    row.key = qpht_pkg::KEY_W'(k);
    row.typed = 1'b1;
    row.want.slot = qpht_pkg::SLOT_W'(slot);
    row.want.status = st;
    row.want.probe_count = qpht_pkg::CNT_W'(pc);
    dir_rows.push_back(row);
  endfunction

  task automatic offer(input logic rt, input logic [qpht_pkg::KEY_W-1:0] k, input logic typed,
                       input table_result_t want);
    table_result_t got;
    req_bus.valid <= 1'b1;
    req_bus.req_type <= rt;
    req_bus.key <= k;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
    got = probe_table(rt, k);
    awaited_results.push_back(typed ? want : got);
    if (rt) begin
      inserts_sent++;
    end else begin
      finds_sent++;
    end
  endtask

  task automatic write_reg(input qpht_pkg::cfg_idx_t idx,
                           input logic [qpht_pkg::CFG_DATA_W-1:0] val);
    req_bus.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
    if (idx == qpht_pkg::CFG_HASH_MOD) begin
      cur_mod = val[qpht_pkg::MOD_W-1:0];
    end else begin
      cur_limit = val[qpht_pkg::LIMIT_W-1:0];
    end
  endtask

  // result side: stall pattern, long hold-off and checking
  initial begin : result_side
    table_result_t want;
    int unsigned   hold_left;
    int unsigned   mode_left;
    int unsigned   mode;
    hold_left = 0;
    mode_left = 0;
    mode = 0;
    res_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (res_bus.valid && res_bus.ready) begin
        results_seen++;
        if (awaited_results.size() == 0) begin
          errors++;
          $display("%0t unexpected result: slot %0d status %0d probe_count %0d", $time,
                   res_bus.slot, res_bus.status, res_bus.probe_count);
        end else begin
          want = awaited_results.pop_front();
          if (res_bus.slot !== want.slot) begin
            errors++;
            $display("%0t slot mismatch: expected %0d, actual %0d", $time, want.slot,
                     res_bus.slot);
          end
          if (res_bus.status !== want.status) begin
            errors++;
            $display("%0t status mismatch: expected %0d, actual %0d", $time, want.status,
                     res_bus.status);
          end
          if (res_bus.probe_count !== want.probe_count) begin
            errors++;
            $display("%0t probe_count mismatch: expected %0d, actual %0d", $time,
                     want.probe_count, res_bus.probe_count);
          end
        end
        if (res_bus.status < 3) status_seen[res_bus.status]++;
        if (results_seen == 250 || results_seen == 1000) hold_left = 400;
      end
      if (hold_left != 0) begin
        hold_left--;
        res_bus.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 2);
          mode_left = $urandom_range(16, 128);
        end
        mode_left--;
        case (mode)
          0: begin
            res_bus.ready <= 1'b1;
          end
          1: begin
            res_bus.ready <= ($urandom_range(0, 3) != 0);
          end
          default: begin
            res_bus.ready <= ($urandom_range(0, 3) == 0);
          end
        endcase
      end
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles >= LIMIT_CYCLES) begin
        $display("timeout after %0d cycles, %0d results outstanding", cycles,
                 awaited_results.size());
        $display("quadratic_probe_hash_table_unit_tb failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    dir_row_t                   row;
    table_result_t              none;
    int unsigned                p;
    int unsigned                n;
    int unsigned                burst;
    int unsigned                gap;
    int unsigned                pick;
    int unsigned                m_eff;
    logic                       rt;
    logic [qpht_pkg::KEY_W-1:0] k;
    logic [31:0]                wide;
    none = '0;
    errors = 0;
    results_seen = 0;
    finds_sent = 0;
    inserts_sent = 0;
    settings_used = 0;
    status_seen = '{0, 0, 0};
    for (int s = 0; s < qpht_pkg::TABLE_SIZE; s++) begin
      slot_used[s] = 1'b0;
      slot_key[s] = '0;
    end
    cur_mod = qpht_pkg::HASH_MOD_RST;
    cur_limit = qpht_pkg::PROBE_LIMIT_RST;
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_idx <= qpht_pkg::CFG_HASH_MOD;
    cfg_data <= '0;
    req_bus.valid <= 1'b0;
    req_bus.req_type <= 1'b0;
    req_bus.key <= '0;

    add_known(1'b0, 0, 0, qpht_pkg::RES_EMPTY, 0);
    add_known(1'b1, 0, 0, qpht_pkg::RES_EMPTY, 0);
    add_known(1'b1, 0, 0, qpht_pkg::RES_FOUND, 0);
    add_known(1'b0, 0, 0, qpht_pkg::RES_FOUND, 0);
    add_item(1'b1, 1021);
    add_item(1'b1, 2042);
    add_item(1'b1, 3063);
    add_item(1'b1, 32'h7FFF_FFFF);
    add_item(1'b0, 3063);
    add_reg(qpht_pkg::CFG_PROBE_LIMIT, 0);
    add_known(1'b1, 4084, 0, qpht_pkg::RES_LIMIT, 0);
    add_known(1'b0, 1021, 0, qpht_pkg::RES_LIMIT, 0);
    add_known(1'b0, 0, 0, qpht_pkg::RES_FOUND, 0);
    add_reg(qpht_pkg::CFG_PROBE_LIMIT, 2);
    add_item(1'b1, 5105);
    add_reg(qpht_pkg::CFG_HASH_MOD, 0);
    add_item(1'b0, 32'h4000_0000);
    add_item(1'b1, 77);
    add_reg(qpht_pkg::CFG_HASH_MOD, 2047);
    add_known(1'b1, 2046, 1022, qpht_pkg::RES_EMPTY, 0);
    add_known(1'b1, 32'h7FFF_FFFF, 511, qpht_pkg::RES_EMPTY, 0);
    add_reg(qpht_pkg::CFG_HASH_MOD, 1);
    add_item(1'b0, 2046);
    add_reg(qpht_pkg::CFG_HASH_MOD, 1024);
    add_item(1'b0, 1023);
    add_reg(qpht_pkg::CFG_HASH_MOD, 1021);
    add_reg(qpht_pkg::CFG_PROBE_LIMIT, 1023);
    add_item(1'b0, 5105);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.is_cfg) begin
        write_reg(row.idx, row.data);
      end else begin
        offer(row.rt, row.key, row.typed, row.want);
      end
    end

    for (p = 0; p < NUM_PHASES; p++) begin
      write_reg(qpht_pkg::CFG_HASH_MOD, qpht_pkg::CFG_DATA_W'(phase_mod[p]));
      write_reg(qpht_pkg::CFG_PROBE_LIMIT, qpht_pkg::CFG_DATA_W'(phase_limit[p]));
      m_eff = (phase_mod[p] == 0) ? 1 : phase_mod[p];
      n = 0;
      while (n < phase_items[p]) begin
        burst = $urandom_range(1, 12);
        for (int b = 0; b < burst && n < phase_items[p]; b++) begin
          pick = $urandom_range(0, 99);
          if (pick < 35 || stored_keys.size() == 0) begin
            rt = 1'b1;
            k = rand_key();
          end else if (pick < 60) begin
            rt = 1'b0;
            k = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
          end else if (pick < 72) begin
            rt = 1'b1;
            k = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
          end else if (pick < 85) begin
            // same home slot as a stored key
            rt = 1'($urandom_range(0, 1));
            wide = 32'(stored_keys[$urandom_range(0, stored_keys.size() - 1)])
                   + m_eff * $urandom_range(1, 64);
            k = wide[qpht_pkg::KEY_W-1:0];
          end else begin
            rt = 1'($urandom_range(0, 1));
            k = rand_key();
          end
          offer(rt, k, 1'b0, none);
          n++;
        end
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
        if (gap != 0) begin
          req_bus.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end

    req_bus.valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("sent %0d finds and %0d inserts across %0d register writes", finds_sent,
             inserts_sent, settings_used);
    $display("results: %0d found, %0d empty slot, %0d at probe limit", status_seen[0],
             status_seen[1], status_seen[2]);
    if (errors == 0 && awaited_results.size() == 0) begin
      $display("quadratic_probe_hash_table_unit_tb passed");
    end else begin
      $display("quadratic_probe_hash_table_unit_tb failed");
    end
    $finish;
  end

endmodule
